// File: design/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// types and constants shared by the positional list store
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 4;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_FETCH,
        S_CAPTURE,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic [1:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        status_t                  status;
        logic [CNT_W-1:0]         item_count;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

// File: design/pls_ram.sv
// ----------------------------------------------------------------------------
// pls_ram
// entry store: one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pls_ram (
    input  logic                          clk,
    input  pls_pkg::ram_req_t             req,
    output logic [pls_pkg::DATA_W-1:0]    rdata
);

    logic [pls_pkg::DATA_W-1:0] mem [pls_pkg::DEPTH];
    logic [pls_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl
// command sequencer: checks, shifts entries through the store, replies
// ----------------------------------------------------------------------------
module pls_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  pls_pkg::request_t             request,
    input  logic [pls_pkg::CNT_W-1:0]     cap_eff,
    input  logic [pls_pkg::DATA_W-1:0]    rdata,
    output pls_pkg::ram_req_t             ram_req,
    output logic                          busy,
    output logic                          done,
    output pls_pkg::result_t              result
);

    pls_pkg::state_t                   state_reg, state_next;
    logic [1:0]                        cmd_reg, cmd_next;
    logic [pls_pkg::ADDR_W-1:0]        pos_reg, pos_next;
    logic [pls_pkg::DATA_W-1:0]        val_reg, val_next;
    logic [pls_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [pls_pkg::CNT_W-1:0]         moves_reg, moves_next;
    logic [pls_pkg::ADDR_W-1:0]        src_reg, src_next;
    logic [pls_pkg::ADDR_W-1:0]        prev_src_reg, prev_src_next;
    logic                              pend_reg, pend_next;
    logic [pls_pkg::DATA_W-1:0]        rd_val_reg, rd_val_next;
    pls_pkg::status_t                  status_reg, status_next;
    logic [pls_pkg::CNT_W-1:0]         req_pos;
    logic                              is_insert;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pls_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        moves_reg    <= moves_next;
        src_reg      <= src_next;
        prev_src_reg <= prev_src_next;
        rd_val_reg   <= rd_val_next;
        status_reg   <= status_next;
    end

    assign req_pos   = pls_pkg::CNT_W'(request.position);
    assign is_insert = (cmd_reg == pls_pkg::CMD_INSERT);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        moves_next    = moves_reg;
        src_next      = src_reg;
        prev_src_next = prev_src_reg;
        pend_next     = pend_reg;
        rd_val_next   = rd_val_reg;
        status_next   = status_reg;
        ram_req       = '0;

        case (state_reg)
            pls_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = request.command;
                    pos_next    = pls_pkg::ADDR_W'(request.position);
                    val_next    = request.value;
                    rd_val_next = '0;
                    status_next = pls_pkg::ST_OK;
                    pend_next   = 1'b0;
                    state_next  = pls_pkg::S_REPLY;
                    case (pls_pkg::cmd_t'(request.command))
                        pls_pkg::CMD_INSERT:
                        begin
                            if (count_reg >= cap_eff)
                            begin
                                status_next = pls_pkg::ST_FULL;
                            end
                            else if (req_pos > count_reg)
                            begin
                                status_next = pls_pkg::ST_RANGE;
                            end
                            else
                            begin
                                moves_next = count_reg - req_pos;
                                src_next   = pls_pkg::ADDR_W'(count_reg - 1'b1);
                                state_next = pls_pkg::S_SHIFT;
                            end
                        end
                        pls_pkg::CMD_REMOVE:
                        begin
                            if (req_pos >= count_reg)
                            begin
                                status_next = pls_pkg::ST_RANGE;
                            end
                            else
                            begin
                                moves_next = count_reg - req_pos - 1'b1;
                                src_next   = pls_pkg::ADDR_W'(req_pos + 1'b1);
                                state_next = pls_pkg::S_SHIFT;
                            end
                        end
                        pls_pkg::CMD_READ:
                        begin
                            if (req_pos >= count_reg)
                            begin
                                status_next = pls_pkg::ST_RANGE;
                            end
                            else
                            begin
                                state_next = pls_pkg::S_FETCH;
                            end
                        end
                        default:
                        begin
                            status_next = pls_pkg::ST_RANGE;
                        end
                    endcase
                end
            end

            pls_pkg::S_SHIFT:
            begin
                // write back the entry read in the previous cycle
                if (pend_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.wdata = rdata;
                    ram_req.waddr = is_insert ? prev_src_reg + 1'b1 : prev_src_reg - 1'b1;
                end
                if (moves_reg != '0)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = src_reg;
                    prev_src_next = src_reg;
                    src_next      = is_insert ? src_reg - 1'b1 : src_reg + 1'b1;
                    moves_next    = moves_reg - 1'b1;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (is_insert)
                        begin
                            state_next = pls_pkg::S_PUT;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            state_next = pls_pkg::S_REPLY;
                        end
                    end
                end
            end

            pls_pkg::S_PUT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                ram_req.wdata = val_reg;
                count_next    = count_reg + 1'b1;
                state_next    = pls_pkg::S_REPLY;
            end

            pls_pkg::S_FETCH:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = pos_reg;
                state_next    = pls_pkg::S_CAPTURE;
            end

            pls_pkg::S_CAPTURE:
            begin
                rd_val_next = rdata;
                state_next  = pls_pkg::S_REPLY;
            end

            pls_pkg::S_REPLY:
            begin
                state_next = pls_pkg::S_IDLE;
            end

            default:
            begin
                state_next = pls_pkg::S_IDLE;
            end
        endcase
    end

    assign busy              = (state_reg != pls_pkg::S_IDLE);
    assign done              = (state_reg == pls_pkg::S_REPLY);
    assign result.read_value = rd_val_reg;
    assign result.status     = status_reg;
    assign result.item_count = count_reg;

endmodule

// File: design/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// ordered list of signed 32-bit values with insert, remove and read at a
// position, configured through an apb-style register port
// ----------------------------------------------------------------------------
// sequence: a refused transaction replies directly; a read fetches, captures, replies;
//   an insert shifts n entries, puts the value, replies; a remove shifts n entries, replies
// throughput: one transaction at a time; entries move one per cycle through
//   the single-port-pair entry memory, next start taken the cycle after done
// reset: list empty, capacity_limit 16; entry memory is not cleared
// results are strobed on done for one cycle; the receiver cannot stall
module positional_list_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pls_pkg::PADDR_W-1:0]    paddr,
    input  logic [pls_pkg::PDATA_W-1:0]    pwdata,
    output logic [pls_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           start,
    input  pls_pkg::request_t              request,
    output logic                           busy,
    output logic                           done,
    output pls_pkg::result_t               result
);

    logic [pls_pkg::CAP_W-1:0]   capacity_reg, capacity_next;
    logic [pls_pkg::CNT_W-1:0]   cap_eff;
    logic                        cfg_write;
    logic [pls_pkg::DATA_W-1:0]  rdata;
    pls_pkg::ram_req_t           ram_req;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_write)
        begin
            capacity_next = pwdata[pls_pkg::CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= pls_pkg::CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    assign prdata = (paddr[2] == 1'b0) ?
                    pls_pkg::PDATA_W'(capacity_reg) : '0;

    assign cap_eff = (pls_pkg::CNT_W'(capacity_reg) > pls_pkg::CNT_W'(pls_pkg::DEPTH)) ?
                     pls_pkg::CNT_W'(pls_pkg::DEPTH) : pls_pkg::CNT_W'(capacity_reg);

    pls_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .cap_eff (cap_eff),
        .rdata   (rdata),
        .ram_req (ram_req),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    pls_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a transaction");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.item_count <= pls_pkg::CNT_W'(pls_pkg::DEPTH)))
        else $error("item count above depth");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != pls_pkg::ST_OK)) |-> (result.read_value == '0))
        else $error("refused transaction returned data");

endmodule

// File: dv/tb_positional_list_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_store
// self-checking bench for the positional list store: a queue-fed driver issues
// insert, remove and read transactions with random gaps, an apb sequence
// changes the capacity between phases, and a monitor predicts each result
// from its own copy of the list and compares it field by field
// ----------------------------------------------------------------------------
module tb_positional_list_store;

    localparam logic [1:0]                  CMD_UNUSED   = 2'd3;
    localparam logic [pls_pkg::PADDR_W-1:0] REG_CAPACITY = '0;
    localparam int                          CYCLE_LIMIT  = 200000;
    localparam int                          PHASES       = 8;
    localparam int                          PHASE_ITEMS  = 50;
    localparam int                          PHASE_CAPS [PHASES] = '{31, 1, 0, 5, 16, 2, 31, 16};

    typedef enum logic [2:0] {
        APB_IDLE,
        APB_WR_ACCESS,
        APB_RD_SETUP,
        APB_RD_ACCESS,
        APB_RELEASE
    } apb_step_t;

    typedef struct {
        bit                           is_cfg;
        bit                           fit;
        bit                           calm;
        pls_pkg::request_t            req;
        logic [pls_pkg::PDATA_W-1:0]  cfg_value;
    } pending_op_t;

    logic                         clk     = 1'b0;
    logic                         rst_n   = 1'b0;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [pls_pkg::PADDR_W-1:0]  paddr   = '0;
    logic [pls_pkg::PDATA_W-1:0]  pwdata  = '0;
    logic [pls_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;
    logic                         start   = 1'b0;
    pls_pkg::request_t            request = '0;
    logic                         busy;
    logic                         done;
    pls_pkg::result_t             result;

    pending_op_t                  pending_ops [$];
    pls_pkg::result_t             expected_results [$];
    logic [pls_pkg::DATA_W-1:0]   list_vals [pls_pkg::DEPTH];
    int unsigned                  list_count = 0;
    logic [pls_pkg::CAP_W-1:0]    cap_limit  = pls_pkg::CAP_RESET;
    logic                         req_taken  = 1'b0;
    apb_step_t                    apb_step   = APB_IDLE;
    int unsigned                  gap_left   = 0;
    int unsigned                  cycle_count = 0;
    int unsigned                  error_count = 0;

    positional_list_store dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    function automatic void add_req(logic [1:0] cmd, logic [pls_pkg::POS_W-1:0] pos,
                                    logic [pls_pkg::DATA_W-1:0] val, bit fit, bit calm);
        pending_op_t op;
        op.is_cfg           = 1'b0;
        op.fit              = fit;
        op.calm             = calm;
        op.req.command      = cmd;
        op.req.position     = pos;
        op.req.value        = val;
        op.cfg_value        = '0;
        pending_ops.push_back(op);
    endfunction

    function automatic void add_cfg(logic [pls_pkg::PDATA_W-1:0] val);
        pending_op_t op;
        op.is_cfg    = 1'b1;
        op.fit       = 1'b0;
        op.calm      = 1'b0;
        op.req       = '0;
        op.cfg_value = val;
        pending_ops.push_back(op);
    endfunction

    function automatic logic [pls_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // list prediction: updates the shadow list and returns the expected result
    function automatic pls_pkg::result_t list_store_step(pls_pkg::request_t r);
        pls_pkg::result_t res;
        int unsigned      room;
        room           = (cap_limit > pls_pkg::DEPTH) ? pls_pkg::DEPTH : cap_limit;
        res.read_value = '0;
        res.status     = pls_pkg::ST_OK;
        case (r.command)
            pls_pkg::CMD_INSERT:
            begin
                if (list_count >= room)
                    res.status = pls_pkg::ST_FULL;
                else if (r.position > list_count)
                    res.status = pls_pkg::ST_RANGE;
                else
                begin
                    for (int k = list_count; k > r.position; k--)
                        list_vals[k] = list_vals[k-1];
                    list_vals[r.position] = r.value;
                    list_count++;
                end
            end
            pls_pkg::CMD_REMOVE:
            begin
                if (r.position >= list_count)
                    res.status = pls_pkg::ST_RANGE;
                else
                begin
                    for (int k = r.position; k + 1 < list_count; k++)
                        list_vals[k] = list_vals[k+1];
                    list_count--;
                end
            end
            pls_pkg::CMD_READ:
            begin
                if (r.position >= list_count)
                    res.status = pls_pkg::ST_RANGE;
                else
                    res.read_value = list_vals[r.position];
            end
            default:
                res.status = pls_pkg::ST_RANGE;
        endcase
        res.item_count = pls_pkg::CNT_W'(list_count);
        return res;
    endfunction

    // driver
    always @(negedge clk)
    begin
        pending_op_t op;
        int unsigned top;
        if (rst_n)
        begin
            if (start && !req_taken)
            begin
                // hold the transaction until it is taken
            end
            else if (apb_step != APB_IDLE)
            begin
                case (apb_step)
                    APB_WR_ACCESS:
                    begin
                        penable  <= 1'b1;
                        apb_step <= APB_RD_SETUP;
                    end
                    APB_RD_SETUP:
                    begin
                        penable  <= 1'b0;
                        pwrite   <= 1'b0;
                        apb_step <= APB_RD_ACCESS;
                    end
                    APB_RD_ACCESS:
                    begin
                        penable  <= 1'b1;
                        apb_step <= APB_RELEASE;
                    end
                    default:
                    begin
                        psel     <= 1'b0;
                        penable  <= 1'b0;
                        apb_step <= APB_IDLE;
                    end
                endcase
            end
            else if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_ops.size() == 0)
                start <= 1'b0;
            else if (pending_ops[0].is_cfg)
            begin
                start <= 1'b0;
                if (!start && !busy && expected_results.size() == 0)
                begin
                    op       = pending_ops.pop_front();
                    psel     <= 1'b1;
                    penable  <= 1'b0;
                    pwrite   <= 1'b1;
                    paddr    <= REG_CAPACITY;
                    pwdata   <= op.cfg_value;
                    apb_step <= APB_WR_ACCESS;
                end
            end
            else
            begin
                op = pending_ops.pop_front();
                if (op.fit)
                begin
                    if (op.req.command == pls_pkg::CMD_INSERT)
                    begin
                        top = (list_count > 15) ? 15 : list_count;
                        op.req.position = pls_pkg::POS_W'($urandom_range(0, top));
                    end
                    else
                        op.req.position = (list_count == 0) ? '0 :
                                          pls_pkg::POS_W'($urandom_range(0, list_count - 1));
                end
                request  <= op.req;
                start    <= 1'b1;
                gap_left <= (!op.calm && $urandom_range(0, 3) == 0) ?
                            $urandom_range(1, 15) : 0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        pls_pkg::result_t want;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= start && !busy;
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", result.read_value, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.read_value !== want.read_value)
                        report_mismatch("read_value", result.read_value, want.read_value);
                    if (result.status !== want.status)
                        report_mismatch("status", 32'(result.status), 32'(want.status));
                    if (result.item_count !== want.item_count)
                        report_mismatch("item_count", 32'(result.item_count),
                                        32'(want.item_count));
                end
            end
            if (start && !busy)
                expected_results.push_back(list_store_step(request));
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == REG_CAPACITY)
                        cap_limit <= pwdata[pls_pkg::CAP_W-1:0];
                end
                else if (prdata !== pls_pkg::PDATA_W'(cap_limit))
                    report_mismatch("capacity_limit readback", prdata,
                                    pls_pkg::PDATA_W'(cap_limit));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int          roll;
        int          pick;
        bit          grow;
        bit          calm;
        logic [1:0]  cmd;

        // empty list, unused command, insert past the end, extremes
        add_req(pls_pkg::CMD_READ,   4'd0,  32'h1234_5678, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_REMOVE, 4'd0,  32'h0,         1'b0, 1'b0);
        add_req(CMD_UNUSED,          4'd3,  32'hdead_beef, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_INSERT, 4'd1,  32'h1,         1'b0, 1'b0);
        add_req(pls_pkg::CMD_INSERT, 4'd0,  32'h7fff_ffff, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_INSERT, 4'd0,  32'h8000_0000, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_INSERT, 4'd2,  32'hffff_ffff, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_INSERT, 4'd1,  32'h0,         1'b0, 1'b0);
        add_req(pls_pkg::CMD_INSERT, 4'd15, 32'h5555_aaaa, 1'b0, 1'b0);
        for (int p = 0; p < 5; p++)
            add_req(pls_pkg::CMD_READ, pls_pkg::POS_W'(p), 32'h0, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_REMOVE, 4'd15, 32'h0, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_REMOVE, 4'd1,  32'h0, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_READ,   4'd1,  32'h0, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_REMOVE, 4'd2,  32'h0, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_REMOVE, 4'd0,  32'h0, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_READ,   4'd0,  32'h0, 1'b0, 1'b0);
        // zero capacity
        add_cfg(32'd0);
        add_req(pls_pkg::CMD_INSERT, 4'd0, 32'h0bad_cafe, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_READ,   4'd0, 32'h0,         1'b0, 1'b0);
        // capacity lowered below the count
        add_cfg(32'd16);
        add_req(pls_pkg::CMD_INSERT, 4'd1, 32'h0000_0005, 1'b0, 1'b0);
        add_cfg(32'd1);
        add_req(pls_pkg::CMD_INSERT, 4'd0, 32'h0000_0006, 1'b0, 1'b0);
        add_req(pls_pkg::CMD_REMOVE, 4'd0, 32'h0,         1'b0, 1'b0);
        add_req(pls_pkg::CMD_READ,   4'd0, 32'h0,         1'b0, 1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            add_cfg(pls_pkg::PDATA_W'(PHASE_CAPS[ph]));
            calm = (ph == 3 || ph == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                grow = (n < PHASE_ITEMS / 2);
                if (roll < 15)
                    add_req(2'($urandom_range(0, 3)), pls_pkg::POS_W'($urandom_range(0, 15)),
                            pick_value(), 1'b0, calm);
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < (grow ? 55 : 25))
                        cmd = pls_pkg::CMD_INSERT;
                    else if (pick < (grow ? 75 : 70))
                        cmd = pls_pkg::CMD_REMOVE;
                    else
                        cmd = pls_pkg::CMD_READ;
                    add_req(cmd, '0, pick_value(), 1'b1, calm);
                end
            end
        end

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || apb_step != APB_IDLE || start || busy)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never arrived", expected_results.size(), 0);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
